// File: sv/srpa_pkg.sv
// Shared types, codes and defaults for the sparse row product accumulator.
// No dependencies; every other file refers to it by scoped names.
package srpa_pkg;

    localparam int DEF_WINDOW_COLS = 1024;
    localparam int DEF_C_ROWS      = 1024;
    localparam int DEF_C_ELEMS     = 4096;

    // request codes on req_type
    localparam logic [2:0] REQ_LOAD_PTR  = 3'd0;
    localparam logic [2:0] REQ_LOAD_ELEM = 3'd1;
    localparam logic [2:0] REQ_BEGIN     = 3'd2;
    localparam logic [2:0] REQ_LEFT      = 3'd3;
    localparam logic [2:0] REQ_DRAIN     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DRAINED       = 2'd0;
    localparam logic [1:0] ST_EMPTY         = 2'd1;
    localparam logic [1:0] ST_OUT_OF_WINDOW = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_PTR,
        OP_LOAD_ELEM,
        OP_BEGIN,
        OP_LEFT,
        OP_DRAIN
    } op_t;

    // one classified request, as queued between front and back
    typedef struct packed {
        op_t         op;
        logic [9:0]  row;
        logic [31:0] position;
        logic [12:0] count;
        logic [31:0] column;
        logic [31:0] value;
        logic [31:0] local_col;
        logic        in_window;
    } item_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PTR,
        BK_ELEM,
        BK_ACC,
        BK_UPD,
        BK_DR_LIST,
        BK_DR_ACC,
        BK_CLR_RD,
        BK_CLR_WR
    } bk_state_t;

    function automatic op_t decode_req(input logic [2:0] req);
        op_t op;
        case (req)
            REQ_LOAD_PTR:  op = OP_LOAD_PTR;
            REQ_LOAD_ELEM: op = OP_LOAD_ELEM;
            REQ_BEGIN:     op = OP_BEGIN;
            REQ_LEFT:      op = OP_LEFT;
            REQ_DRAIN:     op = OP_DRAIN;
            default:       op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

// File: sv/sparse_row_product_accumulator.sv
// Top level of the row-wise sparse product engine with a dense accumulator.
// Depends on srpa_pkg, srpa_front and srpa_back.
//
// Load C row pointers (req 0) and C elements (req 1) first, then for each
// result row issue a begin row (req 2), the left-row elements (req 3) and
// drain items (req 4) until last is seen. After reset the block sweeps the
// accumulator memory once, one entry per cycle; it holds in_stall high until
// that pass ends (col_base writes are taken). Items pass through a two-entry
// queue into a sequencer that owns single port memories, so timing is set by
// that sequencer: loads, empty drains and unknown requests finish in idle; a
// left element reads its row pointer, then each element of its C row, with
// one accumulator read-modify-write per valid element (none for a slot
// marked empty); a drain reads the list, then the accumulator, then gives
// its result; a begin row reads and clears each entry still pending. A
// result waits in the output register while the next item is queued;
// out_stall only holds the sequencer when a new result is due.
// Write col_base only while the block is idle.
module sparse_row_product_accumulator #(
    parameter int WINDOW_COLS = srpa_pkg::DEF_WINDOW_COLS,
    parameter int C_ROWS      = srpa_pkg::DEF_C_ROWS,
    parameter int C_ELEMS     = srpa_pkg::DEF_C_ELEMS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                col_base_we,
    input  logic [31:0]         col_base_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          req_type,
    input  logic [9:0]          row,
    input  logic [31:0]         position,
    input  logic [12:0]         count,
    input  logic [31:0]         column,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [31:0]         out_column,
    output logic signed [63:0]  sum,
    output logic [31:0]         out_position,
    output logic                last,
    output logic [10:0]         remaining
);

    logic [31:0]     col_base_reg;
    srpa_pkg::item_t item;
    logic            item_valid;
    logic            item_pop;
    logic            clearing;

    // hold the window base; the user must write it only while idle, not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_base_reg <= '0;
        end
        else if (col_base_we)
        begin
            col_base_reg <= col_base_wdata;
        end
    end

    // classify and queue requests
    srpa_front #(
        .WINDOW_COLS (WINDOW_COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .row        (row),
        .position   (position),
        .count      (count),
        .column     (column),
        .value      (value),
        .col_base   (col_base_reg),
        .hold       (clearing),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    // execute: walk rows, accumulate, drain
    srpa_back #(
        .WINDOW_COLS (WINDOW_COLS),
        .C_ROWS      (C_ROWS),
        .C_ELEMS     (C_ELEMS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .col_base     (col_base_reg),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_column   (out_column),
        .sum          (sum),
        .out_position (out_position),
        .last         (last),
        .remaining    (remaining)
    );

endmodule

// File: sv/srpa_front.sv
// Front end: classifies incoming requests and queues them (two entries).
// Depends on srpa_pkg.
module srpa_front #(
    parameter int WINDOW_COLS = srpa_pkg::DEF_WINDOW_COLS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          req_type,
    input  logic [9:0]          row,
    input  logic [31:0]         position,
    input  logic [12:0]         count,
    input  logic [31:0]         column,
    input  logic signed [31:0]  value,
    input  logic [31:0]         col_base,
    input  logic                hold,
    output srpa_pkg::item_t     item,
    output logic                item_valid,
    input  logic                item_pop
);

    srpa_pkg::item_t q_reg [2];
    srpa_pkg::item_t incoming;
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push;

    always_comb
    begin
        incoming.op        = srpa_pkg::decode_req(req_type);
        incoming.row       = row;
        incoming.position  = position;
        incoming.count     = count;
        incoming.column    = column;
        incoming.value     = value;
        incoming.local_col = column - col_base;
        incoming.in_window = incoming.local_col < 32'(WINDOW_COLS);
    end

    assign in_stall   = hold || (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item       = q_reg[rd_ptr_reg];
    assign item_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(item_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: sv/srpa_back.sv
// Back end: row pointer, element, accumulator and list memories, the
// sequencer that walks rows and drains entries, and the result register.
// Depends on srpa_pkg.
module srpa_back #(
    parameter int WINDOW_COLS = srpa_pkg::DEF_WINDOW_COLS,
    parameter int C_ROWS      = srpa_pkg::DEF_C_ROWS,
    parameter int C_ELEMS     = srpa_pkg::DEF_C_ELEMS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  srpa_pkg::item_t     item,
    input  logic                item_valid,
    output logic                item_pop,
    input  logic [31:0]         col_base,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [31:0]         out_column,
    output logic signed [63:0]  sum,
    output logic [31:0]         out_position,
    output logic                last,
    output logic [10:0]         remaining
);

    localparam int WW     = $clog2(WINDOW_COLS);
    localparam int RW     = (C_ROWS > 1) ? $clog2(C_ROWS) : 1;
    localparam int EW     = (C_ELEMS > 1) ? $clog2(C_ELEMS) : 1;
    localparam int LW     = WW + 1;
    localparam int PTR_W  = 1 + EW + 13;
    localparam int ELEM_W = 1 + WW + 32;
    localparam int ACC_W  = 65;

    // memories
    logic [PTR_W-1:0]  ptr_mem  [C_ROWS];
    logic [ELEM_W-1:0] elem_mem [C_ELEMS];
    logic [ACC_W-1:0]  acc_mem  [WINDOW_COLS];
    logic [WW-1:0]     list_mem [WINDOW_COLS];

    logic [PTR_W-1:0]  ptr_rd_reg;
    logic [ELEM_W-1:0] elem_rd_reg;
    logic [ACC_W-1:0]  acc_rd_reg;
    logic [WW-1:0]     list_rd_reg;

    logic              ptr_we, ptr_re;
    logic [RW-1:0]     ptr_waddr, ptr_raddr;
    logic [PTR_W-1:0]  ptr_wdata;
    logic              elem_we, elem_re;
    logic [EW-1:0]     elem_waddr, elem_raddr;
    logic [ELEM_W-1:0] elem_wdata;
    logic              acc_we, acc_re;
    logic [WW-1:0]     acc_waddr, acc_raddr;
    logic [ACC_W-1:0]  acc_wdata;
    logic              list_we, list_re;
    logic [WW-1:0]     list_waddr, list_raddr, list_wdata;

    srpa_pkg::bk_state_t state_reg, state_next;

    logic [WW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [EW:0]       slot_reg, slot_next;
    logic [12:0]       len_reg, len_next;
    logic [31:0]       b_reg, b_next;
    logic [63:0]       prod_reg, prod_next;
    logic [WW-1:0]     col_reg, col_next;
    logic [LW-1:0]     list_size_reg, list_size_next;
    logic [WW-1:0]     drain_idx_reg, drain_idx_next;
    logic [31:0]       wr_pos_reg, wr_pos_next;
    logic [31:0]       begin_pos_reg, begin_pos_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       out_column_reg, out_column_next;
    logic [63:0]       sum_reg, sum_next;
    logic [31:0]       out_position_reg, out_position_next;
    logic              last_reg, last_next;
    logic [10:0]       remaining_reg, remaining_next;

    logic              row_ok, pos_ok, out_free, slot_end, list_empty;
    logic              ptr_big;
    logic [EW-1:0]     ptr_start;
    logic [12:0]       ptr_len;
    logic              e_valid;
    logic [WW-1:0]     e_col;
    logic [31:0]       e_val;
    logic              a_seen;
    logic [63:0]       a_sum;
    logic [LW:0]       tail_full;
    logic [WW-1:0]     tail;
    logic [WW-1:0]     di_inc;

    assign row_ok     = 32'(item.row) < 32'(C_ROWS);
    assign pos_ok     = item.position < 32'(C_ELEMS);
    assign out_free   = !out_valid_reg || !out_stall;
    assign slot_end   = slot_reg >= (EW+1)'(C_ELEMS);
    assign list_empty = (list_size_reg == '0);

    assign ptr_big   = ptr_rd_reg[PTR_W-1];
    assign ptr_start = ptr_rd_reg[PTR_W-2 -: EW];
    assign ptr_len   = ptr_rd_reg[12:0];
    assign e_valid   = elem_rd_reg[ELEM_W-1];
    assign e_col     = elem_rd_reg[32 +: WW];
    assign e_val     = elem_rd_reg[31:0];
    assign a_seen    = acc_rd_reg[64];
    assign a_sum     = acc_rd_reg[63:0];

    always_comb
    begin
        tail_full = (LW+1)'(drain_idx_reg) + (LW+1)'(list_size_reg);
        if (tail_full >= (LW+1)'(WINDOW_COLS))
        begin
            tail = WW'(tail_full - (LW+1)'(WINDOW_COLS));
        end
        else
        begin
            tail = WW'(tail_full);
        end
        di_inc = (drain_idx_reg == WW'(WINDOW_COLS - 1)) ? '0 : drain_idx_reg + 1'b1;
    end

    assign clearing = (state_reg == srpa_pkg::BK_CLEAR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srpa_pkg::BK_CLEAR:
            begin
                if (clr_cnt_reg == WW'(WINDOW_COLS - 1))
                begin
                    state_next = srpa_pkg::BK_IDLE;
                end
            end
            srpa_pkg::BK_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.op)
                        srpa_pkg::OP_LEFT:
                        begin
                            if (row_ok)
                            begin
                                state_next = srpa_pkg::BK_PTR;
                            end
                        end
                        srpa_pkg::OP_BEGIN:
                        begin
                            if (!list_empty)
                            begin
                                state_next = srpa_pkg::BK_CLR_RD;
                            end
                        end
                        srpa_pkg::OP_DRAIN:
                        begin
                            if (!list_empty)
                            begin
                                state_next = srpa_pkg::BK_DR_LIST;
                            end
                        end
                        default: state_next = srpa_pkg::BK_IDLE;
                    endcase
                end
            end
            srpa_pkg::BK_PTR: state_next = srpa_pkg::BK_ELEM;
            srpa_pkg::BK_ELEM:
            begin
                if (len_reg == '0 || slot_end)
                begin
                    state_next = srpa_pkg::BK_IDLE;
                end
                else
                begin
                    state_next = srpa_pkg::BK_ACC;
                end
            end
            srpa_pkg::BK_ACC:
                state_next = e_valid ? srpa_pkg::BK_UPD : srpa_pkg::BK_ELEM;
            srpa_pkg::BK_UPD: state_next = srpa_pkg::BK_ELEM;
            srpa_pkg::BK_DR_LIST: state_next = srpa_pkg::BK_DR_ACC;
            srpa_pkg::BK_DR_ACC:
            begin
                if (out_free)
                begin
                    state_next = srpa_pkg::BK_IDLE;
                end
            end
            srpa_pkg::BK_CLR_RD: state_next = srpa_pkg::BK_CLR_WR;
            srpa_pkg::BK_CLR_WR:
            begin
                if (list_size_reg == LW'(1))
                begin
                    state_next = srpa_pkg::BK_IDLE;
                end
                else
                begin
                    state_next = srpa_pkg::BK_CLR_RD;
                end
            end
            default: state_next = srpa_pkg::BK_IDLE;
        endcase
    end

    // datapath and memory port control
    always_comb
    begin
        item_pop   = 1'b0;
        ptr_we     = 1'b0;
        ptr_waddr  = RW'(item.row);
        ptr_wdata  = {!pos_ok, EW'(item.position), item.count};
        ptr_re     = 1'b0;
        ptr_raddr  = RW'(item.row);
        elem_we    = 1'b0;
        elem_waddr = EW'(item.position);
        elem_wdata = {1'b1, WW'(item.local_col), item.value};
        elem_re    = 1'b0;
        elem_raddr = slot_reg[EW-1:0];
        acc_we     = 1'b0;
        acc_waddr  = col_reg;
        acc_wdata  = '0;
        acc_re     = 1'b0;
        acc_raddr  = e_col;
        list_we    = 1'b0;
        list_waddr = tail;
        list_wdata = col_reg;
        list_re    = 1'b0;
        list_raddr = drain_idx_reg;

        clr_cnt_next   = clr_cnt_reg;
        slot_next      = slot_reg;
        len_next       = len_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        col_next       = col_reg;
        list_size_next = list_size_reg;
        drain_idx_next = drain_idx_reg;
        wr_pos_next    = wr_pos_reg;
        begin_pos_next = begin_pos_reg;

        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        out_column_next   = out_column_reg;
        sum_next          = sum_reg;
        out_position_next = out_position_reg;
        last_next         = last_reg;
        remaining_next    = remaining_reg;

        case (state_reg)
            srpa_pkg::BK_CLEAR:
            begin
                acc_we       = 1'b1;
                acc_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            srpa_pkg::BK_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.op)
                        srpa_pkg::OP_LOAD_PTR:
                        begin
                            item_pop = 1'b1;
                            ptr_we   = row_ok;
                        end
                        srpa_pkg::OP_LOAD_ELEM:
                        begin
                            if (item.in_window)
                            begin
                                item_pop = 1'b1;
                                elem_we  = pos_ok;
                            end
                            else if (out_free)
                            begin
                                // mark the slot empty and flag the column
                                item_pop          = 1'b1;
                                elem_we           = pos_ok;
                                elem_wdata        = '0;
                                out_valid_next    = 1'b1;
                                status_next       = srpa_pkg::ST_OUT_OF_WINDOW;
                                out_column_next   = item.column;
                                sum_next          = '0;
                                out_position_next = item.position;
                                last_next         = 1'b0;
                                remaining_next    = '0;
                            end
                        end
                        srpa_pkg::OP_BEGIN:
                        begin
                            item_pop       = 1'b1;
                            begin_pos_next = item.position;
                            if (list_empty)
                            begin
                                drain_idx_next = '0;
                                wr_pos_next    = item.position;
                            end
                        end
                        srpa_pkg::OP_LEFT:
                        begin
                            item_pop = 1'b1;
                            ptr_re   = row_ok;
                            b_next   = item.value;
                        end
                        srpa_pkg::OP_DRAIN:
                        begin
                            if (!list_empty)
                            begin
                                item_pop = 1'b1;
                                list_re  = 1'b1;
                            end
                            else if (out_free)
                            begin
                                item_pop          = 1'b1;
                                out_valid_next    = 1'b1;
                                status_next       = srpa_pkg::ST_EMPTY;
                                out_column_next   = '0;
                                sum_next          = '0;
                                out_position_next = '0;
                                last_next         = 1'b0;
                                remaining_next    = '0;
                            end
                        end
                        default: item_pop = 1'b1;
                    endcase
                end
            end
            srpa_pkg::BK_PTR:
            begin
                slot_next = ptr_big ? (EW+1)'(C_ELEMS) : {1'b0, ptr_start};
                len_next  = ptr_len;
            end
            srpa_pkg::BK_ELEM:
            begin
                if (!(len_reg == '0 || slot_end))
                begin
                    elem_re   = 1'b1;
                    slot_next = slot_reg + 1'b1;
                    len_next  = len_reg - 1'b1;
                end
            end
            srpa_pkg::BK_ACC:
            begin
                if (e_valid)
                begin
                    acc_re    = 1'b1;
                    prod_next = $signed(b_reg) * $signed(e_val);
                    col_next  = e_col;
                end
            end
            srpa_pkg::BK_UPD:
            begin
                acc_we    = 1'b1;
                acc_wdata = {1'b1, a_sum + prod_reg};
                if (!a_seen)
                begin
                    list_we        = 1'b1;
                    list_size_next = list_size_reg + 1'b1;
                end
            end
            srpa_pkg::BK_DR_LIST:
            begin
                acc_re    = 1'b1;
                acc_raddr = list_rd_reg;
                col_next  = list_rd_reg;
            end
            srpa_pkg::BK_DR_ACC:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = srpa_pkg::ST_DRAINED;
                    out_column_next   = 32'(col_reg) + col_base;
                    sum_next          = a_sum;
                    out_position_next = wr_pos_reg;
                    last_next         = (list_size_reg == LW'(1));
                    remaining_next    = 11'(list_size_reg);
                    acc_we            = 1'b1;
                    list_size_next    = list_size_reg - 1'b1;
                    drain_idx_next    = (list_size_reg == LW'(1)) ? '0 : di_inc;
                    wr_pos_next       = wr_pos_reg + 1'b1;
                end
            end
            srpa_pkg::BK_CLR_RD:
            begin
                list_re = 1'b1;
            end
            srpa_pkg::BK_CLR_WR:
            begin
                acc_we         = 1'b1;
                acc_waddr      = list_rd_reg;
                list_size_next = list_size_reg - 1'b1;
                if (list_size_reg == LW'(1))
                begin
                    drain_idx_next = '0;
                    wr_pos_next    = begin_pos_reg;
                end
                else
                begin
                    drain_idx_next = di_inc;
                end
            end
            default: item_pop = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[ptr_waddr] <= ptr_wdata;
        end
        if (ptr_re)
        begin
            ptr_rd_reg <= ptr_mem[ptr_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re)
        begin
            elem_rd_reg <= elem_mem[elem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (acc_re)
        begin
            acc_rd_reg <= acc_mem[acc_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (list_re)
        begin
            list_rd_reg <= list_mem[list_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg         <= slot_next;
        len_reg          <= len_next;
        b_reg            <= b_next;
        prod_reg         <= prod_next;
        col_reg          <= col_next;
        begin_pos_reg    <= begin_pos_next;
        status_reg       <= status_next;
        out_column_reg   <= out_column_next;
        sum_reg          <= sum_next;
        out_position_reg <= out_position_next;
        last_reg         <= last_next;
        remaining_reg    <= remaining_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srpa_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            list_size_reg <= '0;
            drain_idx_reg <= '0;
            wr_pos_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            list_size_reg <= list_size_next;
            drain_idx_reg <= drain_idx_next;
            wr_pos_reg    <= wr_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_column   = out_column_reg;
    assign sum          = sum_reg;
    assign out_position = out_position_reg;
    assign last         = last_reg;
    assign remaining    = remaining_reg;

endmodule

// File: sv/srpa_checker.sv
// Port-level checks for the sparse row product accumulator, bound to the top.
// Depends on srpa_pkg and sparse_row_product_accumulator.
module srpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [1:0]          status,
    input logic [31:0]         out_column,
    input logic signed [63:0]  sum,
    input logic [31:0]         out_position,
    input logic                last,
    input logic [10:0]         remaining
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(sum)
            && $stable(out_column) && $stable(out_position) && $stable(remaining))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == srpa_pkg::ST_DRAINED || status == srpa_pkg::ST_EMPTY
            || status == srpa_pkg::ST_OUT_OF_WINDOW)
        else $error("undefined status code");

    a_flag_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != srpa_pkg::ST_DRAINED |-> sum == 64'sd0
            && remaining == 11'd0 && !last)
        else $error("non-drain result carries entry fields");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == srpa_pkg::ST_DRAINED |-> remaining != 11'd0
            && (last == (remaining == 11'd1)))
        else $error("drain count and last disagree");

endmodule

bind sparse_row_product_accumulator srpa_checker u_srpa_checker (.*);

// File: bench/sparse_row_product_accumulator_test.sv
// Self-checking bench for sparse_row_product_accumulator: row products by
// a dense accumulator, checked item by item. Depends on srpa_pkg and the RTL.
`timescale 1ns / 1ps
module sparse_row_product_accumulator_test;

    localparam int WIN      = srpa_pkg::DEF_WINDOW_COLS;
    localparam int NROWS    = srpa_pkg::DEF_C_ROWS;
    localparam int NELEMS   = srpa_pkg::DEF_C_ELEMS;
    localparam int SETTLE   = 2 * WIN + 200;   // a begin row may clear a full list
    localparam int LIMIT    = 1000000;
    localparam int HOLD_LEN = 3000;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] column;
        logic [63:0] sum;
        logic [31:0] position;
        logic        last;
        logic [10:0] remaining;
    } product_t;

    logic clk;
    logic rst_n;
    logic col_base_we;
    logic [31:0] col_base_wdata;
    logic in_valid;
    logic in_stall;
    logic [2:0] req_type;
    logic [9:0] row;
    logic [31:0] position;
    logic [12:0] count;
    logic [31:0] column;
    logic signed [31:0] value;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic [31:0] out_column;
    logic signed [63:0] sum;
    logic [31:0] out_position;
    logic last;
    logic [10:0] remaining;

    sparse_row_product_accumulator u_top (
        .clk(clk), .rst_n(rst_n),
        .col_base_we(col_base_we), .col_base_wdata(col_base_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .row(row), .position(position), .count(count),
        .column(column), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_column(out_column), .sum(sum),
        .out_position(out_position), .last(last), .remaining(remaining)
    );

    // shadow copy of the block's state
    logic [31:0] sh_base;
    logic [31:0] sh_row_start [NROWS];
    logic [12:0] sh_row_len [NROWS];
    logic [31:0] sh_local [NELEMS];
    logic [31:0] sh_cval [NELEMS];
    bit          sh_cvalid [NELEMS];
    logic [63:0] sh_acc [WIN];
    bit          sh_seen [WIN];
    logic [9:0]  sh_order [WIN];
    int          sh_pending;
    int          sh_head;
    logic [31:0] sh_wpos;

    // which stores the stimulus has written, so no walk reads unwritten data
    bit row_loaded [NROWS];
    bit slot_loaded [NELEMS];
    int loaded_rows[$];

    product_t pending_products[$];
    int errors;
    int items_sent;
    int products_seen;
    int cycles;
    bit quiet;          // no idling on either side
    bit hold_request;
    logic hold_long;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("sparse_row_product_accumulator_test NOT OK");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, products_seen);
        errors++;
    endtask

    // add one product into the shadow accumulator, listing the column once
    task automatic shadow_accumulate(input int j, input logic [63:0] prod);
        if (!sh_seen[j]) begin
            sh_order[(sh_head + sh_pending) % WIN] = j[9:0];
            sh_seen[j] = 1'b1;
            sh_pending++;
        end
        sh_acc[j] = sh_acc[j] + prod;
    endtask

    // advance the shadow state by one accepted item and queue any result it gives
    task automatic predict_product(input logic [2:0] rq, input logic [9:0] r,
                                   input logic [31:0] pos, input logic [12:0] cnt,
                                   input logic [31:0] col, input logic signed [31:0] val);
        product_t p;
        logic [31:0] loc;
        longint bv;
        longint cv;
        longint slot;
        int j;
        p = '{default: '0};
        case (rq)
            srpa_pkg::REQ_LOAD_PTR: begin
                sh_row_start[r] = pos;
                sh_row_len[r] = cnt;
            end
            srpa_pkg::REQ_LOAD_ELEM: begin
                loc = col - sh_base;
                if (loc >= WIN) begin
                    if (pos < NELEMS) sh_cvalid[pos] = 1'b0;
                    p.status = srpa_pkg::ST_OUT_OF_WINDOW;
                    p.column = col;
                    p.position = pos;
                    pending_products.push_back(p);
                end else if (pos < NELEMS) begin
                    sh_local[pos] = loc;
                    sh_cval[pos] = val;
                    sh_cvalid[pos] = 1'b1;
                end
            end
            srpa_pkg::REQ_BEGIN: begin
                // drop every pending entry
                while (sh_pending > 0) begin
                    j = sh_order[sh_head];
                    sh_acc[j] = '0;
                    sh_seen[j] = 1'b0;
                    sh_head = (sh_head + 1) % WIN;
                    sh_pending--;
                end
                sh_head = 0;
                sh_wpos = pos;
            end
            srpa_pkg::REQ_LEFT: begin
                bv = val;
                for (longint t = 0; t < sh_row_len[r]; t++) begin
                    slot = longint'(sh_row_start[r]) + t;
                    if (slot >= NELEMS) break;
                    if (sh_cvalid[slot] && sh_local[slot] < WIN) begin
                        cv = $signed(sh_cval[slot]);
                        shadow_accumulate(sh_local[slot], bv * cv);
                    end
                end
            end
            srpa_pkg::REQ_DRAIN: begin
                if (sh_pending == 0) begin
                    p.status = srpa_pkg::ST_EMPTY;
                end else begin
                    j = sh_order[sh_head];
                    p.status = srpa_pkg::ST_DRAINED;
                    p.column = j + sh_base;
                    p.sum = sh_acc[j];
                    p.position = sh_wpos;
                    p.last = (sh_pending == 1);
                    p.remaining = 11'(sh_pending);
                    sh_acc[j] = '0;
                    sh_seen[j] = 1'b0;
                    sh_head = (sh_head + 1) % WIN;
                    sh_pending--;
                    if (sh_pending == 0) sh_head = 0;
                    sh_wpos = sh_wpos + 1;
                end
                pending_products.push_back(p);
            end
            default: ;
        endcase
    endtask

    // offer one item, hold it until accepted, then maybe leave a gap
    task automatic send_item(input logic [2:0] rq, input logic [9:0] r,
                             input logic [31:0] pos, input logic [12:0] cnt,
                             input logic [31:0] col, input logic [31:0] val);
        req_type <= rq;
        row <= r;
        position <= pos;
        count <= cnt;
        column <= col;
        value <= val;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_product(rq, r, pos, cnt, col, val);
        items_sent++;
        if (rq == srpa_pkg::REQ_LOAD_PTR && !row_loaded[r]) begin
            row_loaded[r] = 1'b1;
            loaded_rows.push_back(r);
        end
        if (rq == srpa_pkg::REQ_LOAD_ELEM && pos < NELEMS) slot_loaded[pos] = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_col_base(input logic [31:0] b);
        col_base_we <= 1'b1;
        col_base_wdata <= b;
        @(posedge clk);
        col_base_we <= 1'b0;
        sh_base = b;
    endtask

    // a row can be walked only if every slot it reaches has been written
    function automatic bit row_walkable(input int r);
        longint slot;
        if (!row_loaded[r]) return 1'b0;
        for (longint t = 0; t < sh_row_len[r]; t++) begin
            slot = longint'(sh_row_start[r]) + t;
            if (slot >= NELEMS) break;
            if (!slot_loaded[slot]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // compare each accepted result against the oldest expectation
    always @(posedge clk) begin
        product_t e;
        if (rst_n && out_valid && !out_stall) begin
            products_seen++;
            if (pending_products.size() == 0) begin
                report("unexpected result, column", 64'(out_column), '0);
            end else begin
                e = pending_products.pop_front();
                if (status !== e.status) report("status", status, e.status);
                if (out_column !== e.column) report("out_column", out_column, e.column);
                if (sum !== e.sum) report("sum", sum, e.sum);
                if (out_position !== e.position)
                    report("out_position", out_position, e.position);
                if (last !== e.last) report("last", last, e.last);
                if (remaining !== e.remaining) report("remaining", remaining, e.remaining);
            end
        end
    end

    // receiver: random stall bursts, plus a long hold when requested
    initial begin
        out_stall = 1'b0;
        hold_long = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !hold_long) begin
                hold_long <= 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_long <= 1'b0;
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19) - 1) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 30)) @(posedge clk);
            end
        end
    end

    // extremes, every request type, window edges, walk past store, discard
    task automatic test_directed();
        write_col_base(32'h0);
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 0, 0, 32'd0, 32'h7FFFFFFF);
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 1, 0, 32'd1023, 32'h80000000);
        // out of window
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 2, 0, 32'd1024, 32'd5);
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 3, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        // slot past store, then flag with a bad slot
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 5000, 0, 32'd7, 32'd9);
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0);
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 4094, 0, 32'd1023, 32'hFFFFFFFF);
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 4095, 0, 32'd0, 32'd3);
        send_item(srpa_pkg::REQ_LOAD_PTR, 0, 0, 4, 0, 0);
        // runs past store, starts past store
        send_item(srpa_pkg::REQ_LOAD_PTR, 10'h3FF, 4094, 13'd4096, 0, 0);
        send_item(srpa_pkg::REQ_LOAD_PTR, 1, 5000, 3, 0, 0);
        send_item(srpa_pkg::REQ_BEGIN, 0, 32'hFFFFFFFF, 0, 0, 0);
        send_item(srpa_pkg::REQ_LEFT, 0, 0, 0, 0, 32'h7FFFFFFF);
        send_item(srpa_pkg::REQ_LEFT, 0, 0, 0, 0, 32'h80000000);
        send_item(srpa_pkg::REQ_LEFT, 10'h3FF, 0, 0, 0, 32'hFFFFFFFF);
        send_item(srpa_pkg::REQ_LEFT, 1, 0, 0, 0, 32'd1);
        // position wraps, then two empty drains
        repeat (3) send_item(srpa_pkg::REQ_DRAIN, 0, 0, 0, 0, 0);
        send_item(srpa_pkg::REQ_DRAIN, 0, 0, 0, 0, 0);
        send_item(srpa_pkg::REQ_LEFT, 0, 0, 0, 0, 32'd2);
        // discard pending
        send_item(srpa_pkg::REQ_BEGIN, 0, 32'd100, 0, 0, 0);
        send_item(srpa_pkg::REQ_DRAIN, 0, 0, 0, 0, 0);
        send_item(3'd5, 0, 0, 0, 0, 0);
        send_item(3'd7, 10'h3FF, 32'hFFFFFFFF, 13'h1FFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        wait_idle();
    endtask

    // rows of random content: loads, a begin, left elements, then drains
    task automatic run_rows(input int item_budget);
        int stop_at;
        int r;
        int n;
        logic [31:0] col;
        logic [31:0] slot;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            n = $urandom_range(0, 6);
            repeat (n) begin
                slot = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 511);
                col = ($urandom_range(0, 9) == 0) ? $urandom()
                                                  : sh_base + $urandom_range(0, WIN - 1);
                send_item(srpa_pkg::REQ_LOAD_ELEM, $urandom(), slot, $urandom(), col,
                          $urandom());
            end
            n = $urandom_range(0, 3);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0: send_item(srpa_pkg::REQ_LOAD_PTR, $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom());
                    1: send_item(srpa_pkg::REQ_LOAD_PTR, $urandom(), $urandom_range(0, 511),
                                 $urandom_range(0, 64), $urandom(), $urandom());
                    default: send_item(srpa_pkg::REQ_LOAD_PTR, $urandom(),
                                       $urandom_range(0, 511), $urandom_range(0, 8),
                                       $urandom(), $urandom());
                endcase
            end
            send_item(srpa_pkg::REQ_BEGIN, $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom());
            n = $urandom_range(1, 6);
            repeat (n) begin
                for (int tries = 0; tries < 20 && loaded_rows.size() > 0; tries++) begin
                    r = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
                    if (row_walkable(r)) begin
                        send_item(srpa_pkg::REQ_LEFT, r, $urandom(), $urandom(), $urandom(),
                                  $urandom());
                        break;
                    end
                end
            end
            if ($urandom_range(0, 19) == 0)
                send_item($urandom_range(5, 7), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom());
            // usually drain the row fully, now and then stop early or overrun
            n = sh_pending;
            if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
            else if ($urandom_range(0, 3) == 0) n = n + 1;
            repeat (n) send_item(srpa_pkg::REQ_DRAIN, $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom());
        end
    endtask

    task automatic test_window_settings();
        logic [31:0] bases[4];
        bases = '{32'h0, $urandom(), 32'hFFFFFFFF, 32'hFFFFFE00};
        foreach (bases[i]) begin
            wait_idle();
            write_col_base(bases[i]);
            run_rows(300);
        end
        wait_idle();
        write_col_base(32'h0);
    endtask

    // hold the output long enough that the input stalls behind it
    task automatic test_backpressure();
        wait_idle();
        send_item(srpa_pkg::REQ_LOAD_ELEM, 0, 600, 0, 32'd17, 32'd3);
        send_item(srpa_pkg::REQ_LOAD_PTR, 600, 600, 1, 0, 0);
        send_item(srpa_pkg::REQ_BEGIN, 0, 32'd0, 0, 0, 0);
        send_item(srpa_pkg::REQ_LEFT, 600, 0, 0, 0, 32'd7);
        hold_request = 1'b1;
        repeat (30) send_item(srpa_pkg::REQ_DRAIN, 0, 0, 0, 0, 0);
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        col_base_we = 1'b0;
        col_base_wdata = '0;
        in_valid = 1'b0;
        req_type = '0;
        row = '0;
        position = '0;
        count = '0;
        column = '0;
        value = '0;
        quiet = 1'b0;
        hold_request = 1'b0;
        errors = 0;
        items_sent = 0;
        products_seen = 0;
        sh_base = '0;
        sh_pending = 0;
        sh_head = 0;
        sh_wpos = '0;
        for (int i = 0; i < NROWS; i++) begin
            sh_row_start[i] = '0;
            sh_row_len[i] = '0;
            row_loaded[i] = 1'b0;
        end
        for (int i = 0; i < NELEMS; i++) begin
            sh_local[i] = '0;
            sh_cval[i] = '0;
            sh_cvalid[i] = 1'b0;
            slot_loaded[i] = 1'b0;
        end
        for (int i = 0; i < WIN; i++) begin
            sh_acc[i] = '0;
            sh_seen[i] = 1'b0;
            sh_order[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_window_settings();
        test_backpressure();
        // finish with both sides running flat out
        quiet = 1'b1;
        run_rows(200);
        wait_idle();

        $display("covered %0d items and %0d results over four window bases,",
                 items_sent, products_seen);
        $display("including discarded rows, empty drains, window flags and a long output hold");
        if (errors == 0 && pending_products.size() == 0) begin
            $display("sparse_row_product_accumulator_test OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending_products.size());
            $display("sparse_row_product_accumulator_test NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/srpa_pkg.sv
sv/srpa_front.sv
sv/srpa_back.sv
sv/sparse_row_product_accumulator.sv
sv/srpa_checker.sv
bench/sparse_row_product_accumulator_test.sv
